// ===== design/mic_pkg.sv =====
package mic_pkg;

  // Table geometry.
  localparam int VALUE_BITS  = 10;
  localparam int COUNT_BITS  = 16;
  localparam int TABLE_DEPTH = 1 << VALUE_BITS;

  // Fixed field widths of the item and result channels.
  localparam int VALUE_W   = 10;
  localparam int COMMAND_W = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ZERO = '0;
  localparam logic [VALUE_BITS-1:0] INDEX_LAST = '1;

  // Command codes.
  localparam logic [COMMAND_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_PROBE = 2'd1;
  localparam logic [COMMAND_W-1:0] CMD_CLEAR = 2'd2;

  // State of the table clearing sweep.
  typedef struct packed {
    logic                  active;
    logic [VALUE_BITS-1:0] addr;
  } sweep_t;

endpackage

// ===== design/mic_if.sv =====
interface mic_item_if import mic_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COMMAND_W-1:0] command;
  logic [VALUE_W-1:0]   value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface mic_result_if import mic_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [VALUE_W-1:0] value_out;

  modport source (output valid, output hit, output value_out, input ready);
  modport sink   (input valid, input hit, input value_out, output ready);
endinterface

// ===== design/mic_count_ram.sv =====
module mic_count_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  // Read before write: a read and a write of the same entry at one edge
  // return the old contents.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== design/mic_clear_seq.sv =====
module mic_clear_seq import mic_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output sweep_t sweep
);

  logic                  active;
  logic [VALUE_BITS-1:0] addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b1;
      addr   <= '0;
    end else if (active) begin
      addr <= addr + 1'b1;
      if (addr == INDEX_LAST) begin
        active <= 1'b0;
      end
    end else if (start) begin
      active <= 1'b1;
      addr   <= '0;
    end
  end

  assign sweep.active = active;
  assign sweep.addr   = addr;

endmodule

// ===== design/multiset_intersection_count.sv =====
// Multiset intersection counter. A table of 2^VALUE_BITS occurrence counts of
// COUNT_BITS bits is held in a single-port-read, single-port-write RAM with a
// registered read. A load item adds one to the count of its value (saturating),
// a probe item takes one away if the count is above zero and returns one
// result carrying hit and the value; load and clear items return nothing, and
// the unused command code is accepted and ignored. Load and probe items are
// taken one per cycle while no sweep runs and no probe waits: each is read on
// acceptance and written back as it leaves the update stage, and a same-value
// item that follows immediately picks up the updated count from a bypass
// register. A probe waits in the update stage while the output register still
// holds an untaken result. A clear item, and reset itself, start a sweep that
// writes zero to one entry per cycle; no item is accepted until it is done.
module multiset_intersection_count import mic_pkg::*; (
  input logic         clk,
  input logic         rst,
  mic_item_if.sink    item,
  mic_result_if.source result
);

  logic                  accept;
  logic [VALUE_BITS-1:0] idx;
  sweep_t                sweep;

  // Update stage: the item whose count is being read back from the RAM.
  logic                  s1_valid;
  logic                  s1_probe;
  logic [VALUE_BITS-1:0] s1_idx;
  logic                  s1_go;

  // Bypass for an item that follows a write to the same entry.
  logic                  byp;
  logic [COUNT_BITS-1:0] byp_data;

  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] new_count;
  logic                  cur_nonzero;

  logic                  wr_en;
  logic [VALUE_BITS-1:0] wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  // Result register.
  logic                  res_valid;
  logic                  res_hit;
  logic [VALUE_W-1:0]    res_value;

  // The value is masked to the table width; that masked value is echoed.
  assign idx    = VALUE_BITS'(item.value);
  assign accept = item.valid && item.ready;

  // A probe can only leave the update stage when the result slot is free
  // or is being emptied at this edge.
  assign s1_go      = s1_valid && (!s1_probe || !res_valid || result.ready);
  assign item.ready = !sweep.active && (!s1_valid || s1_go);

  mic_clear_seq u_clear (
    .clk   (clk),
    .rst   (rst),
    .start (accept && (item.command == CMD_CLEAR)),
    .sweep (sweep)
  );

  mic_count_ram #(
    .ADDR_W (VALUE_BITS),
    .DATA_W (COUNT_BITS)
  ) u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign cur         = byp ? byp_data : rd_data;
  assign cur_nonzero = (cur != COUNT_ZERO);

  always_comb begin
    if (s1_probe) begin
      new_count = cur_nonzero ? cur - 1'b1 : cur;
    end else begin
      new_count = (cur == COUNT_MAX) ? cur : cur + 1'b1;
    end
  end

  // The sweep owns the write port while it runs; otherwise the update
  // stage writes back its new count as it leaves.
  always_comb begin
    if (sweep.active) begin
      wr_en   = 1'b1;
      wr_addr = sweep.addr;
      wr_data = COUNT_ZERO;
    end else begin
      wr_en   = s1_go;
      wr_addr = s1_idx;
      wr_data = new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= (item.command == CMD_LOAD) || (item.command == CMD_PROBE);
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // The RAM read of an item accepted in the same cycle as a write to its
  // entry returns the old count, so the new one is kept aside for it.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_probe <= (item.command == CMD_PROBE);
      s1_idx   <= idx;
      byp      <= s1_go && (s1_idx == idx);
      byp_data <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go && s1_probe) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_probe) begin
      res_hit   <= cur_nonzero;
      res_value <= VALUE_W'(s1_idx);
    end
  end

  assign result.valid     = res_valid;
  assign result.hit       = res_hit;
  assign result.value_out = res_value;

endmodule

// ===== sim/mic_tb_pkg.sv =====
package mic_tb_pkg;
  import mic_pkg::*;

  // One expected probe answer.
  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value;
  } probe_result_t;

  // Keeps its own copy of the count table and the queue of probe answers
  // that the block still owes.
  class count_scoreboard;
    logic [COUNT_BITS-1:0] counts [TABLE_DEPTH];
    probe_result_t         owed [$];
    int                    errors;

    function new();
      foreach (counts[i]) counts[i] = COUNT_ZERO;
      errors = 0;
    endfunction

    function int owed_count();
      return owed.size();
    endfunction

    task report(string msg);
      if (errors < 50) $display("ERROR: %0t %s", $realtime, msg);
      errors++;
    endtask

    // Applies one accepted item to the count table.
    function void note_item(logic [COMMAND_W-1:0] command, logic [VALUE_W-1:0] value);
      logic [VALUE_BITS-1:0] idx;
      probe_result_t         answer;
      idx = value[VALUE_BITS-1:0];
      case (command)
        CMD_LOAD: begin
          if (counts[idx] != COUNT_MAX) counts[idx] = counts[idx] + 1'b1;
        end
        CMD_PROBE: begin
          answer.hit   = (counts[idx] != COUNT_ZERO);
          answer.value = VALUE_W'(idx);
          if (answer.hit) counts[idx] = counts[idx] - 1'b1;
          owed = {owed, answer};
        end
        CMD_CLEAR: begin
          foreach (counts[i]) counts[i] = COUNT_ZERO;
        end
        default: ;
      endcase
    endfunction

    task check_result(logic hit, logic [VALUE_W-1:0] value_out);
      probe_result_t want;
      if (owed.size() == 0) begin
        report($sformatf("result with nothing owed: hit=%0b value_out=%0d", hit, value_out));
        return;
      end
      want = owed.pop_front();
      if (hit !== want.hit)
        report($sformatf("hit is %0b, want %0b for value %0d", hit, want.hit, want.value));
      if (value_out !== want.value)
        report($sformatf("value_out is %0d, want %0d", value_out, want.value));
    endtask

    task check_drained();
      while (owed.size() != 0) begin
        report($sformatf("probe answer never came for value %0d", owed[0].value));
        void'(owed.pop_front());
      end
    endtask
  endclass

endpackage

// ===== sim/tb_multiset_intersection_count.sv =====
// Testbench for the multiset intersection counter. Items are driven at the
// falling edge of the clock and both channels are sampled at the rising edge.
// A scoreboard object keeps its own count table, works out the answer owed
// for every accepted probe and compares the answers field by field as they
// are taken from the block.
module tb_multiset_intersection_count;
  timeunit 1ns;
  timeprecision 1ps;

  import mic_pkg::*;
  import mic_tb_pkg::*;

  // The fourth command code is not used by the block and must be ignored.
  localparam logic [COMMAND_W-1:0] CMD_UNUSED = 2'd3;

  // A clear, and reset itself, stall the item channel for a whole sweep of the
  // table, so the watchdog must allow comfortably more than one sweep plus the
  // longest idle stretch on either side.
  localparam int SWEEP_CYCLES   = TABLE_DEPTH;
  localparam int WATCHDOG_LIMIT = 5 * SWEEP_CYCLES;
  localparam int SETTLE_CYCLES  = SWEEP_CYCLES + 100;
  localparam int PHASE_ITEMS    = 200;

  logic clk = 1'b0;
  logic rst;

  mic_item_if   item_ch ();
  mic_result_if result_ch ();

  multiset_intersection_count dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always #6 clk = ~clk;

  count_scoreboard sb = new();

  // Percentages of cycles in which the sender holds back and the receiver
  // refuses an answer; the stimulus changes them from phase to phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int item_total = 0;
  int quiet_cycles = 0;

  // The receiver decides on each falling edge whether it takes an answer.
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.hit, result_ch.value_out);
  end

  // The watchdog counts cycles in which neither channel moves an item. A
  // healthy block never stays silent much longer than one table sweep.
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item, with a random idle stretch first, and returns just after
  // the rising edge at which it is accepted. Valid is left high so that the
  // next item can follow without a gap.
  task automatic send_item(logic [COMMAND_W-1:0] command, logic [VALUE_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.command <= command;
    item_ch.value   <= value;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(command, value);
    if (command != CMD_UNUSED) item_total++;
  endtask

  // Holds the sender back until every owed answer has been taken.
  task automatic wait_for_answers();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (sb.owed_count() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] any_value();
    return VALUE_W'($urandom_range(TABLE_DEPTH - 1));
  endfunction

  // One random round. Most rounds are a proper intersection: load a small
  // multiset drawn from a few values, then probe with a second one drawn
  // mostly from the same values, and sometimes clear the table afterwards.
  // About half of the values are chosen close together so that same-value items
  // often follow one another. The remaining rounds are unstructured noise,
  // including the unused command.
  task automatic run_round();
    logic [VALUE_W-1:0] pool [$];
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] pick;
    int                 n_pool;
    if ($urandom_range(99) < 80) begin
      n_pool = $urandom_range(1, 6);
      base   = any_value();
      repeat (n_pool) begin
        pick = $urandom_range(1) ? any_value() : base + VALUE_W'($urandom_range(3));
        pool = {pool, pick};
      end
      repeat ($urandom_range(1, 12))
        send_item(CMD_LOAD, pool[$urandom_range(pool.size() - 1)]);
      repeat ($urandom_range(1, 12))
        send_item(CMD_PROBE, ($urandom_range(4) == 0) ? any_value()
                                                       : pool[$urandom_range(pool.size() - 1)]);
      if ($urandom_range(99) < 20) send_item(CMD_CLEAR, any_value());
    end else begin
      repeat ($urandom_range(1, 6))
        send_item(COMMAND_W'($urandom_range(3)), any_value());
    end
  endtask

  initial begin
    int phase_end;
    rst               = 1'b1;
    item_ch.valid     = 1'b0;
    item_ch.command   = CMD_LOAD;
    item_ch.value     = '0;
    result_ch.ready   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items, with neither side idling. An empty counter gives a miss.
    send_item(CMD_PROBE, '0);
    send_item(CMD_LOAD, '0);
    send_item(CMD_LOAD, '1);
    send_item(CMD_LOAD, '1);
    send_item(CMD_LOAD, 10'h2AA);
    send_item(CMD_LOAD, 10'h155);
    // Two hits on the twice-loaded top value, then a miss once it is used up.
    send_item(CMD_PROBE, '1);
    send_item(CMD_PROBE, '1);
    send_item(CMD_PROBE, '1);
    send_item(CMD_PROBE, '0);
    send_item(CMD_PROBE, 10'h2AA);
    send_item(CMD_PROBE, 10'h155);
    // The unused command must neither count a value nor answer.
    send_item(CMD_UNUSED, 10'd5);
    send_item(CMD_PROBE, 10'd5);
    send_item(CMD_LOAD, 10'd7);
    send_item(CMD_UNUSED, 10'd7);
    send_item(CMD_PROBE, 10'd7);
    send_item(CMD_PROBE, 10'd7);
    // A clear empties counts that were loaded before it.
    send_item(CMD_LOAD, 10'd9);
    send_item(CMD_LOAD, 10'h3FE);
    send_item(CMD_CLEAR, '0);
    send_item(CMD_PROBE, 10'd9);
    send_item(CMD_PROBE, 10'h3FE);

    // A burst of loads on one value, then one probe more than was loaded.
    // There is one hit per load and a final miss, and the burst runs the
    // same-value bypass back to back for a long stretch.
    repeat (20) send_item(CMD_LOAD, 10'h3C3);
    repeat (21) send_item(CMD_PROBE, 10'h3C3);
    send_item(CMD_CLEAR, '1);
    wait_for_answers();

    // Random rounds in four idling phases: none, a lazy sender, a slow
    // receiver, and both a little. Between phases the sender waits until
    // every owed answer has been taken.
    item_total = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      phase_end = item_total + PHASE_ITEMS;
      while (item_total < phase_end) run_round();
      wait_for_answers();
    end

    // Let any clear that is still sweeping finish before deciding.
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== multiset_intersection_count.f =====
design/mic_pkg.sv
design/mic_if.sv
design/mic_count_ram.sv
design/mic_clear_seq.sv
design/multiset_intersection_count.sv
sim/mic_tb_pkg.sv
sim/tb_multiset_intersection_count.sv
